/* src/swsr_pkg.sv */
// Shared constants for the stack with search-remove: defaults, operation and status codes.
package swsr_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

/* src/stack_with_search_remove_core.sv */
// Bounded LIFO stack of words with push, pop and search-remove, one memory under a sequencer.
//
// One item at a time: in_stall is high from acceptance until the result item has been taken.
// All stored words sit in one single-port-read, single-port-write memory with a registered
// read. A push writes its word and a pop reads and captures the top entry; a pop on an empty
// stack, a push on a full stack and an unused op code 3 leave the stack as it is. Search-remove
// scans from the top one entry a cycle and then moves each entry above the match down one
// place, one a cycle. After the operation the new top is read back from the memory. No
// clearing pass after reset: read data from entries beyond the fill count is never used.
module stack_with_search_remove_core #(
  parameter int DEPTH      = swsr_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = swsr_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [swsr_pkg::OP_W-1:0]             in_op,
  input  logic signed [DATA_WIDTH-1:0]          in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [DATA_WIDTH-1:0]          out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]            out_position,
  output logic [swsr_pkg::ST_W-1:0]             out_status,
  output logic signed [DATA_WIDTH-1:0]          out_top_value,
  output logic                                  out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0]            out_fill_count
);
  import swsr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POPRD  = 3'd1;
  localparam logic [2:0] S_POPCAP = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_RTOP   = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] rd_val_r, rd_val_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [CW-1:0]         scan_idx_r, scan_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]         cmp_addr_r, cmp_addr_nxt;
  logic [CW-1:0]         sh_ra_r, sh_ra_nxt;
  logic [AW-1:0]         sh_wa_r, sh_wa_nxt;
  logic                  sh_wv_r, sh_wv_nxt;

  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         scan_m1;
  logic [CW-1:0]         sh_ra_m1;

  assign cnt_m1   = count_r - 1'b1;
  assign scan_m1  = scan_idx_r - 1'b1;
  assign sh_ra_m1 = sh_ra_r - 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    rd_val_nxt   = rd_val_r;
    pos_nxt      = pos_r;
    status_nxt   = status_r;
    top_nxt      = top_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_addr_nxt = cmp_addr_r;
    sh_ra_nxt    = sh_ra_r;
    sh_wa_nxt    = sh_wa_r;
    sh_wv_nxt    = sh_wv_r;
    rd_addr      = cnt_m1[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = in_value;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_value;
          rd_val_nxt = '0;
          pos_nxt    = '0;
          status_nxt = ST_OK;
          unique case (in_op)
            OP_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_RTOP;
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_POP_EMPTY;
                state_nxt  = S_RTOP;
              end else begin
                state_nxt = S_POPRD;
              end
            end
            OP_SEARCH: begin
              scan_idx_nxt = count_r;
              cmp_vld_nxt  = 1'b0;
              state_nxt    = S_SCAN;
            end
            default: state_nxt = S_RTOP;
          endcase
        end
      end
      S_POPRD: begin
        rd_addr   = cnt_m1[AW-1:0];
        state_nxt = S_POPCAP;
      end
      S_POPCAP: begin
        rd_val_nxt = rdata_r;
        count_nxt  = cnt_m1;
        state_nxt  = S_RTOP;
      end
      S_SCAN: begin
        // compare runs in the cycle after the read, on the registered read data
        if (cmp_vld_r && (rdata_r == key_r)) begin
          pos_nxt   = count_r - CW'(cmp_addr_r);
          sh_ra_nxt = CW'(cmp_addr_r) + 1'b1;
          sh_wv_nxt = 1'b0;
          state_nxt = S_SHIFT;
        end else if (scan_idx_r != '0) begin
          rd_addr      = scan_m1[AW-1:0];
          cmp_vld_nxt  = 1'b1;
          cmp_addr_nxt = scan_m1[AW-1:0];
          scan_idx_nxt = scan_m1;
        end else if (cmp_vld_r) begin
          cmp_vld_nxt = 1'b0;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RTOP;
        end
      end
      S_SHIFT: begin
        // read entry k while writing the entry read last cycle to k-2
        if (sh_wv_r) begin
          wr_en   = 1'b1;
          wr_addr = sh_wa_r;
          wr_data = rdata_r;
        end
        if (sh_ra_r < count_r) begin
          rd_addr   = sh_ra_r[AW-1:0];
          sh_wa_nxt = sh_ra_m1[AW-1:0];
          sh_wv_nxt = 1'b1;
          sh_ra_nxt = sh_ra_r + 1'b1;
        end else begin
          sh_wv_nxt = 1'b0;
          if (!sh_wv_r) begin
            count_nxt = cnt_m1;
            state_nxt = S_RTOP;
          end
        end
      end
      S_RTOP: begin
        rd_addr   = cnt_m1[AW-1:0];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        top_nxt   = (count_r != '0) ? rdata_r : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      sh_wv_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      sh_wv_r   <= sh_wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    rd_val_r   <= rd_val_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    top_r      <= top_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    sh_ra_r    <= sh_ra_nxt;
    sh_wa_r    <= sh_wa_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_read_value = rd_val_r;
  assign out_position   = pos_r;
  assign out_status     = status_r;
  assign out_top_value  = top_r;
  assign out_is_empty   = (count_r == '0);
  assign out_fill_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_PUSH && count_r != CW'(DEPTH))
      |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the stack");

  a_not_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NOT_FOUND) |-> out_position == '0)
    else $error("position reported without a match");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> out_top_value == '0)
    else $error("empty stack reports a top word");

endmodule
